// ===== hdl/pcfc_pkg.sv =====
package pcfc_pkg;

    // Frame layout
    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] HEADER_BYTES = 17'd6;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd5;

    localparam int unsigned TOTAL_W = 20;
    localparam logic [31:0] SEED_AT_RESET = 32'hAAAA0000;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // Verdict codes
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_ZERO_LENGTH = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_MISMATCH = 3'd4;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data;        // zero unless present
        logic        present;
        logic        plast;
        logic        last;
        logic        need_check;  // verdict rests on the checksum compare
        logic [2:0]  code;        // verdict when need_check is low
        logic [31:0] target;      // received checksum minus seed and length bits
    } fe_item_t;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [4:0] ones16(input logic [15:0] v);
        return {1'b0, ones8(v[7:0])} + {1'b0, ones8(v[15:8])};
    endfunction

endpackage

// ===== hdl/pcfc_ifs.sv =====
interface pcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_last, input ready);
    modport sink (input valid, input in_byte, input frame_last, output ready);
endinterface

interface pcfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       payload_present;
    logic       payload_last;
    logic       frame_done;
    logic       frame_ok;
    logic [2:0] error_code;

    modport source (output valid, output out_byte, output payload_present,
                    output payload_last, output frame_done, output frame_ok,
                    output error_code, input ready);
    modport sink (input valid, input out_byte, input payload_present,
                  input payload_last, input frame_done, input frame_ok,
                  input error_code, output ready);
endinterface

interface pcfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum_seed;

    modport source (output valid, output checksum_seed, input ready);
    modport sink (input valid, input checksum_seed, output ready);
endinterface

// ===== hdl/pcfc_front.sv =====
module pcfc_front (
    input  logic                clk,
    input  logic                rst_n,
    pcfc_in_if.sink             rx,
    pcfc_cfg_if.sink            cfg,
    input  logic                q_full,
    output logic                q_push,
    output pcfc_pkg::fe_item_t  q_item
);

    logic [pcfc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0] rx_chk_reg, rx_chk_next;
    logic [15:0] len_reg, len_next;
    logic [4:0]  len_ones_reg, len_ones_next;
    logic [31:0] seed_reg;

    logic                       accept;
    logic [pcfc_pkg::POS_W-1:0] count;
    logic [pcfc_pkg::POS_W-1:0] pay_off;
    logic [pcfc_pkg::POS_W-1:0] got_pay;
    logic                       in_payload;
    logic                       present;
    logic                       plast;

    assign rx.ready  = !q_full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;

    // Hold the seed; the user must write it only while the block is idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= pcfc_pkg::SEED_AT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            seed_reg <= cfg.checksum_seed;
        end
    end

    // Gather header fields
    always_comb
    begin
        rx_chk_next   = rx_chk_reg;
        len_next      = len_reg;
        len_ones_next = len_ones_reg;
        if (pos_reg < pcfc_pkg::POS_LEN_LO)
        begin
            case (pos_reg[1:0])
                2'd0: rx_chk_next[7:0]   = rx.in_byte;
                2'd1: rx_chk_next[15:8]  = rx.in_byte;
                2'd2: rx_chk_next[23:16] = rx.in_byte;
                2'd3: rx_chk_next[31:24] = rx.in_byte;
                default: rx_chk_next = rx_chk_reg;
            endcase
        end
        else if (pos_reg == pcfc_pkg::POS_LEN_LO)
        begin
            len_next[7:0] = rx.in_byte;
        end
        else if (pos_reg == pcfc_pkg::POS_LEN_HI)
        begin
            len_next[15:8] = rx.in_byte;
            len_ones_next  = pcfc_pkg::ones16({rx.in_byte, len_reg[7:0]});
        end
    end

    // Classify the byte
    assign in_payload = pos_reg >= pcfc_pkg::HEADER_BYTES;
    assign pay_off    = pos_reg - pcfc_pkg::HEADER_BYTES;
    assign present    = in_payload && (pay_off < {1'b0, len_reg});
    assign plast      = present && ((pay_off + 1'b1) == {1'b0, len_reg});
    assign count      = (pos_reg < pcfc_pkg::POS_MAX) ? pos_reg + 1'b1 : pcfc_pkg::POS_MAX;
    assign got_pay    = count - pcfc_pkg::HEADER_BYTES;
    assign pos_next   = rx.frame_last ? '0 : count;

    always_comb
    begin
        q_item            = '0;
        q_item.data       = present ? rx.in_byte : 8'd0;
        q_item.present    = present;
        q_item.plast      = plast;
        q_item.last       = rx.frame_last;
        q_item.target     = rx_chk_reg - seed_reg - {27'd0, len_ones_reg};
        q_item.need_check = 1'b0;
        q_item.code       = pcfc_pkg::ERR_NONE;
        if (rx.frame_last)
        begin
            if (count < pcfc_pkg::HEADER_BYTES)
            begin
                q_item.code = pcfc_pkg::ERR_SHORT_HEADER;
            end
            else if (len_next == 16'd0)
            begin
                q_item.code = pcfc_pkg::ERR_ZERO_LENGTH;
            end
            else if (got_pay < {1'b0, len_next})
            begin
                q_item.code = pcfc_pkg::ERR_TRUNCATED;
            end
            else
            begin
                q_item.need_check = 1'b1;
            end
        end
    end

    // Drop bytes that give no result
    assign q_push = accept && (present || rx.frame_last);

    // Advance frame state; clear it after the closing byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            rx_chk_reg   <= '0;
            len_reg      <= '0;
            len_ones_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (rx.frame_last)
            begin
                rx_chk_reg   <= '0;
                len_reg      <= '0;
                len_ones_reg <= '0;
            end
            else
            begin
                rx_chk_reg   <= rx_chk_next;
                len_reg      <= len_next;
                len_ones_reg <= len_ones_next;
            end
        end
    end

endmodule

// ===== hdl/pcfc_queue.sv =====
module pcfc_queue #(
    parameter int unsigned DEPTH = pcfc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcfc_pkg::fe_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output pcfc_pkg::fe_item_t  pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pcfc_pkg::fe_item_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Wrap pointers and track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/pcfc_back.sv =====
module pcfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  pcfc_pkg::fe_item_t  q_item,
    output logic                q_pop,
    pcfc_out_if.source          tx
);

    logic [pcfc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [pcfc_pkg::TOTAL_W-1:0] sum;
    logic [2:0] code;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       plast_reg;
    logic       done_reg;
    logic       ok_reg;
    logic [2:0] code_reg;

    // Take an entry when the output register is free or being drained
    assign q_pop = q_valid && (!valid_reg || tx.ready);

    // Count payload bits and settle the verdict
    assign sum = total_reg + pcfc_pkg::TOTAL_W'(pcfc_pkg::ones8(q_item.data));

    always_comb
    begin
        code = pcfc_pkg::ERR_NONE;
        if (q_item.last)
        begin
            if (q_item.need_check)
            begin
                code = ({12'd0, sum} == q_item.target) ? pcfc_pkg::ERR_NONE
                                                       : pcfc_pkg::ERR_MISMATCH;
            end
            else
            begin
                code = q_item.code;
            end
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (q_item.last)
        begin
            total_next = '0;
        end
        else if (q_item.present)
        begin
            total_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                total_reg <= total_next;
                valid_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            byte_reg    <= q_item.data;
            present_reg <= q_item.present;
            plast_reg   <= q_item.plast;
            done_reg    <= q_item.last;
            ok_reg      <= q_item.last && (code == pcfc_pkg::ERR_NONE);
            code_reg    <= code;
        end
    end

    assign tx.valid           = valid_reg;
    assign tx.out_byte        = byte_reg;
    assign tx.payload_present = present_reg;
    assign tx.payload_last    = plast_reg;
    assign tx.frame_done      = done_reg;
    assign tx.frame_ok        = ok_reg;
    assign tx.error_code      = code_reg;

endmodule

// ===== hdl/popcount_checksum_frame_checker.sv =====
// Popcount checksum frame checker.
// rx carries one frame byte per transfer (in_byte, frame_last marks the final byte).
// A frame is a 4-byte little-endian checksum, a 2-byte little-endian length and
// the payload. tx gives one result for each payload byte within the stated length
// and one for the closing byte; header bytes and bytes past the length give none.
// The closing result carries frame_done with frame_ok and error_code.
// cfg writes checksum_seed (0xAAAA0000 after reset); write it only while idle.
// Throughput: one byte per cycle while the queue has room and tx takes results.
// Each result is written into a queue entry, then loaded into the output register
// before it is offered on tx; the bit count accumulator in the back end sets the
// one-byte-per-cycle pace. A queue of QUEUE_DEPTH entries sits between front
// and back end.
// When tx stalls, the output register holds its result and rx keeps taking bytes
// until the queue fills; rx.ready then drops. Bytes that give no result never
// enter the queue.
// Reset clears frame state, the queue, the bit count and the output valid flag, and reloads the seed.
module popcount_checksum_frame_checker #(
    parameter int unsigned QUEUE_DEPTH = pcfc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    pcfc_in_if.sink     rx,
    pcfc_out_if.source  tx,
    pcfc_cfg_if.sink    cfg
);

    logic               q_full;
    logic               q_push;
    pcfc_pkg::fe_item_t q_in;
    logic               q_pop;
    logic               q_valid;
    pcfc_pkg::fe_item_t q_out;

    // Parse header and classify bytes
    pcfc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    // Decouple front from back
    pcfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out)
    );

    // Accumulate bits and emit results
    pcfc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_out),
        .q_pop   (q_pop),
        .tx      (tx)
    );

endmodule
